/* rtl/core/stok_pkg.sv */
package stok_pkg;

    // Result field widths (fixed by the record format)
    localparam int LINE_FW = 16;
    localparam int LEN_FW  = 12;
    localparam int MAX_RES = 4;
    localparam int CNT_W   = 3;
    localparam int KW_NUM  = 6;

    typedef logic [4:0] kind_t;
    typedef logic [1:0] rec_type_t;
    typedef logic [1:0] err_t;

    localparam rec_type_t REC_TEXT  = 2'd0;
    localparam rec_type_t REC_END   = 2'd1;
    localparam rec_type_t REC_ERROR = 2'd2;

    localparam err_t ERR_NONE   = 2'd0;
    localparam err_t ERR_SYMBOL = 2'd1;
    localparam err_t ERR_UNTERM = 2'd2;

    localparam kind_t K_IDENT   = 5'd0;
    localparam kind_t K_NUMBER  = 5'd1;
    localparam kind_t K_STRING  = 5'd2;
    localparam kind_t K_COMMENT = 5'd3;
    localparam kind_t K_KW0     = 5'd4;
    localparam kind_t K_PLUS    = 5'd10;
    localparam kind_t K_MINUS   = 5'd11;
    localparam kind_t K_DIV     = 5'd12;
    localparam kind_t K_MUL     = 5'd13;
    localparam kind_t K_ASSIGN  = 5'd14;
    localparam kind_t K_LPAREN  = 5'd15;
    localparam kind_t K_RPAREN  = 5'd16;
    localparam kind_t K_LBRACE  = 5'd17;
    localparam kind_t K_RBRACE  = 5'd18;
    localparam kind_t K_LBRACK  = 5'd19;
    localparam kind_t K_RBRACK  = 5'd20;
    localparam kind_t K_COLON   = 5'd21;
    localparam kind_t K_COMMA   = 5'd22;

    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'd13;
    localparam logic [7:0] CH_SLASH  = "/";
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_N      = "n";

    // Keyword spelling, zero padded to eight positions
    localparam logic [7:0] KW_CHARS [KW_NUM][8] = '{
        '{"f", "u", "n", "c", 8'd0, 8'd0, 8'd0, 8'd0},
        '{"i", "f", 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
        '{"e", "l", "s", "e", 8'd0, 8'd0, 8'd0, 8'd0},
        '{"e", "l", "s", "e", "i", "f", 8'd0, 8'd0},
        '{"e", "x", "t", "e", "r", "n", 8'd0, 8'd0},
        '{"r", "e", "t", "u", "r", "n", 8'd0, 8'd0}
    };
    localparam logic [2:0] KW_LEN [KW_NUM] = '{3'd4, 3'd2, 3'd4, 3'd6, 3'd6, 3'd6};
    localparam logic [2:0] KW_MAXLEN = 3'd6;

    typedef enum logic [7:0] {
        MODE_IDLE    = 8'b0000_0001,
        MODE_IDENT   = 8'b0000_0010,
        MODE_NUMBER  = 8'b0000_0100,
        MODE_STRING  = 8'b0000_1000,
        MODE_ESCAPE  = 8'b0001_0000,
        MODE_SLASH   = 8'b0010_0000,
        MODE_COMMENT = 8'b0100_0000,
        MODE_HALT    = 8'b1000_0000
    } mode_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_input;
    } in_t;

    typedef struct packed {
        rec_type_t             rec_type;
        kind_t                 token_kind;
        logic [7:0]            text_byte;
        logic [LINE_FW-1:0]    line_number;
        logic [LEN_FW-1:0]     token_length;
        err_t                  error_code;
        logic                  last_of_run;
    } res_t;

    typedef struct packed {
        logic [CNT_W-1:0]        count;
        res_t [MAX_RES-1:0]      slot;
    } bundle_t;

    typedef struct packed {
        logic free;
    } obuf_stat_t;

    function automatic logic is_digit(logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_alpha(logic [7:0] c);
        return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
    endfunction

    function automatic kind_t op_kind(logic [7:0] c);
        kind_t k;
        unique case (c)
            "+":     k = K_PLUS;
            "-":     k = K_MINUS;
            "/":     k = K_DIV;
            "*":     k = K_MUL;
            "=":     k = K_ASSIGN;
            "(":     k = K_LPAREN;
            ")":     k = K_RPAREN;
            "{":     k = K_LBRACE;
            "}":     k = K_RBRACE;
            "[":     k = K_LBRACK;
            "]":     k = K_RBRACK;
            ":":     k = K_COLON;
            ",":     k = K_COMMA;
            default: k = K_IDENT;
        endcase
        return k;
    endfunction

endpackage

/* rtl/core/stok_chan_if.sv */
interface stok_chan_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

/* rtl/core/stok_scan.sv */
module stok_scan
    import stok_pkg::*;
#(
    parameter int LINE_BITS   = 16,
    parameter int LENGTH_BITS = 12
) (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    step,
    input  in_t     in_data,
    output bundle_t bundle
);

    mode_t                  mode_reg,  mode_next;
    logic [KW_NUM-1:0]      kw_reg,    kw_next;
    logic [LINE_BITS-1:0]   line_reg,  line_next;
    logic [LINE_BITS-1:0]   sline_reg, sline_next;
    logic [LENGTH_BITS-1:0] bcnt_reg,  bcnt_next;

    res_t [MAX_RES-1:0]     recs;
    logic [CNT_W-1:0]       n_v;
    logic                   do_idle;
    logic [7:0]             c;
    kind_t                  op;

    // drop candidates that do not have byte ch at position pos
    function automatic logic [KW_NUM-1:0] kw_filter(logic [KW_NUM-1:0] kw,
                                                    logic [LENGTH_BITS-1:0] pos,
                                                    logic [7:0] ch);
        logic [KW_NUM-1:0] r;
        logic              in_range;
        r        = kw;
        in_range = pos < LENGTH_BITS'(KW_MAXLEN);
        for (int k = 0; k < KW_NUM; k++) begin
            if (!in_range || (pos[2:0] >= KW_LEN[k]) || (KW_CHARS[k][pos[2:0]] != ch))
            begin
                r[k] = 1'b0;
            end
        end
        return r;
    endfunction

    function automatic kind_t kw_kind(logic [KW_NUM-1:0] kw, logic [LENGTH_BITS-1:0] len);
        kind_t kind;
        kind = K_IDENT;
        for (int k = 0; k < KW_NUM; k++) begin
            if (kw[k] && (len == LENGTH_BITS'(KW_LEN[k])))
            begin
                kind = K_KW0 + kind_t'(k);
            end
        end
        return kind;
    endfunction

    function automatic res_t mk_rec(rec_type_t t, kind_t kind, logic [7:0] ch,
                                    logic [LINE_BITS-1:0] line,
                                    logic [LENGTH_BITS-1:0] len, err_t err);
        res_t r;
        r.rec_type     = t;
        r.token_kind   = kind;
        r.text_byte    = ch;
        r.line_number  = LINE_FW'(line);
        r.token_length = LEN_FW'(len);
        r.error_code   = err;
        r.last_of_run  = 1'b0;
        return r;
    endfunction

    always_comb
    begin
        mode_next  = mode_reg;
        kw_next    = kw_reg;
        line_next  = line_reg;
        sline_next = sline_reg;
        bcnt_next  = bcnt_reg;
        recs       = '0;
        n_v        = '0;
        do_idle    = 1'b0;
        c          = in_data.in_byte;
        op         = op_kind(c);

        if (in_data.end_of_input)
        begin
            unique case (mode_reg) inside
                MODE_IDENT:
                begin
                    recs[n_v[1:0]] = mk_rec(REC_END, kw_kind(kw_next, bcnt_next), 8'd0,
                                            sline_next, bcnt_next, ERR_NONE);
                    n_v = n_v + 1'b1;
                end
                MODE_NUMBER:
                begin
                    recs[n_v[1:0]] = mk_rec(REC_END, K_NUMBER, 8'd0, sline_next,
                                            bcnt_next, ERR_NONE);
                    n_v = n_v + 1'b1;
                end
                MODE_SLASH:
                begin
                    recs[n_v[1:0]] = mk_rec(REC_TEXT, K_DIV, CH_SLASH, sline_next,
                                            '0, ERR_NONE);
                    n_v = n_v + 1'b1;
                    recs[n_v[1:0]] = mk_rec(REC_END, K_DIV, 8'd0, sline_next,
                                            bcnt_next, ERR_NONE);
                    n_v = n_v + 1'b1;
                end
                MODE_COMMENT:
                begin
                    recs[n_v[1:0]] = mk_rec(REC_END, K_COMMENT, 8'd0, sline_next,
                                            bcnt_next, ERR_NONE);
                    n_v = n_v + 1'b1;
                end
                MODE_STRING, MODE_ESCAPE:
                begin
                    recs[n_v[1:0]] = mk_rec(REC_ERROR, K_IDENT, 8'd0, sline_next,
                                            '0, ERR_UNTERM);
                    n_v = n_v + 1'b1;
                    mode_next = MODE_HALT;
                end
                default:
                begin
                end
            endcase
            if (mode_next != MODE_HALT)
            begin
                mode_next = MODE_IDLE;
            end
        end
        else
        begin
            unique case (mode_reg)
                MODE_IDENT:
                begin
                    if (is_alpha(c) || is_digit(c))
                    begin
                        kw_next = kw_filter(kw_next, bcnt_next, c);
                        if (bcnt_next != '1)
                            bcnt_next = bcnt_next + 1'b1;
                        recs[n_v[1:0]] = mk_rec(REC_TEXT, K_IDENT, c, sline_next,
                                                '0, ERR_NONE);
                        n_v = n_v + 1'b1;
                    end
                    else
                    begin
                        recs[n_v[1:0]] = mk_rec(REC_END, kw_kind(kw_next, bcnt_next),
                                                8'd0, sline_next, bcnt_next, ERR_NONE);
                        n_v     = n_v + 1'b1;
                        do_idle = 1'b1;
                    end
                end
                MODE_NUMBER:
                begin
                    if (is_digit(c))
                    begin
                        if (bcnt_next != '1)
                            bcnt_next = bcnt_next + 1'b1;
                        recs[n_v[1:0]] = mk_rec(REC_TEXT, K_NUMBER, c, sline_next,
                                                '0, ERR_NONE);
                        n_v = n_v + 1'b1;
                    end
                    else
                    begin
                        recs[n_v[1:0]] = mk_rec(REC_END, K_NUMBER, 8'd0, sline_next,
                                                bcnt_next, ERR_NONE);
                        n_v     = n_v + 1'b1;
                        do_idle = 1'b1;
                    end
                end
                MODE_STRING:
                begin
                    if (bcnt_next != '1)
                        bcnt_next = bcnt_next + 1'b1;
                    if (c == CH_QUOTE)
                    begin
                        recs[n_v[1:0]] = mk_rec(REC_END, K_STRING, 8'd0, sline_next,
                                                bcnt_next, ERR_NONE);
                        n_v       = n_v + 1'b1;
                        mode_next = MODE_IDLE;
                    end
                    else if (c == CH_BSLASH)
                    begin
                        mode_next = MODE_ESCAPE;
                    end
                    else
                    begin
                        recs[n_v[1:0]] = mk_rec(REC_TEXT, K_STRING, c, sline_next,
                                                '0, ERR_NONE);
                        n_v = n_v + 1'b1;
                    end
                end
                MODE_ESCAPE:
                begin
                    if (bcnt_next != '1)
                        bcnt_next = bcnt_next + 1'b1;
                    if (c == CH_N)
                    begin
                        recs[n_v[1:0]] = mk_rec(REC_TEXT, K_STRING, CH_CR, sline_next,
                                                '0, ERR_NONE);
                        n_v = n_v + 1'b1;
                    end
                    else
                    begin
                        recs[n_v[1:0]] = mk_rec(REC_TEXT, K_STRING, CH_BSLASH, sline_next,
                                                '0, ERR_NONE);
                        n_v = n_v + 1'b1;
                        recs[n_v[1:0]] = mk_rec(REC_TEXT, K_STRING, c, sline_next,
                                                '0, ERR_NONE);
                        n_v = n_v + 1'b1;
                    end
                    mode_next = MODE_STRING;
                end
                MODE_SLASH:
                begin
                    if (c == CH_SLASH)
                    begin
                        if (bcnt_next != '1)
                            bcnt_next = bcnt_next + 1'b1;
                        mode_next = MODE_COMMENT;
                    end
                    else
                    begin
                        recs[n_v[1:0]] = mk_rec(REC_TEXT, K_DIV, CH_SLASH, sline_next,
                                                '0, ERR_NONE);
                        n_v = n_v + 1'b1;
                        recs[n_v[1:0]] = mk_rec(REC_END, K_DIV, 8'd0, sline_next,
                                                bcnt_next, ERR_NONE);
                        n_v     = n_v + 1'b1;
                        do_idle = 1'b1;
                    end
                end
                MODE_COMMENT:
                begin
                    if (c == CH_LF)
                    begin
                        recs[n_v[1:0]] = mk_rec(REC_END, K_COMMENT, 8'd0, sline_next,
                                                bcnt_next, ERR_NONE);
                        n_v     = n_v + 1'b1;
                        do_idle = 1'b1;
                    end
                    else if (bcnt_next != '1)
                    begin
                        bcnt_next = bcnt_next + 1'b1;
                    end
                end
                MODE_IDLE:
                begin
                    do_idle = 1'b1;
                end
                default:
                begin
                end
            endcase

            // byte seen outside any token
            if (do_idle)
            begin
                mode_next = MODE_IDLE;
                if ((c == CH_SPACE) || (c == CH_TAB))
                begin
                end
                else if (c == CH_LF)
                begin
                    if (line_next != '1)
                        line_next = line_next + 1'b1;
                end
                else if ((c == CH_SLASH) || (c == CH_QUOTE))
                begin
                    mode_next  = (c == CH_SLASH) ? MODE_SLASH : MODE_STRING;
                    sline_next = line_next;
                    bcnt_next  = LENGTH_BITS'(1);
                end
                else if (is_digit(c))
                begin
                    mode_next  = MODE_NUMBER;
                    sline_next = line_next;
                    bcnt_next  = LENGTH_BITS'(1);
                    recs[n_v[1:0]] = mk_rec(REC_TEXT, K_NUMBER, c, sline_next, '0, ERR_NONE);
                    n_v = n_v + 1'b1;
                end
                else if (is_alpha(c))
                begin
                    mode_next  = MODE_IDENT;
                    sline_next = line_next;
                    kw_next    = kw_filter('1, '0, c);
                    bcnt_next  = LENGTH_BITS'(1);
                    recs[n_v[1:0]] = mk_rec(REC_TEXT, K_IDENT, c, sline_next, '0, ERR_NONE);
                    n_v = n_v + 1'b1;
                end
                else if (op != K_IDENT)
                begin
                    sline_next = line_next;
                    bcnt_next  = LENGTH_BITS'(1);
                    recs[n_v[1:0]] = mk_rec(REC_TEXT, op, c, sline_next, '0, ERR_NONE);
                    n_v = n_v + 1'b1;
                    recs[n_v[1:0]] = mk_rec(REC_END, op, 8'd0, sline_next, bcnt_next,
                                            ERR_NONE);
                    n_v = n_v + 1'b1;
                end
                else
                begin
                    recs[n_v[1:0]] = mk_rec(REC_ERROR, K_IDENT, 8'd0, line_next, '0,
                                            ERR_SYMBOL);
                    n_v       = n_v + 1'b1;
                    mode_next = MODE_HALT;
                end
            end
        end

        if (n_v != '0)
        begin
            recs[2'(n_v - 1'b1)].last_of_run = 1'b1;
        end

        // a halted scanner says nothing and keeps its state
        if (mode_reg == MODE_HALT)
        begin
            mode_next  = mode_reg;
            kw_next    = kw_reg;
            line_next  = line_reg;
            sline_next = sline_reg;
            bcnt_next  = bcnt_reg;
            recs       = '0;
            n_v        = '0;
        end

        bundle.count = n_v;
        bundle.slot  = recs;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_IDLE;
            kw_reg    <= '1;
            line_reg  <= LINE_BITS'(1);
            sline_reg <= LINE_BITS'(1);
            bcnt_reg  <= '0;
        end
        else if (step)
        begin
            mode_reg  <= mode_next;
            kw_reg    <= kw_next;
            line_reg  <= line_next;
            sline_reg <= sline_next;
            bcnt_reg  <= bcnt_next;
        end
    end

    a_halt_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg == MODE_HALT |=> mode_reg == MODE_HALT)
        else $error("scanner left halt without reset");

    a_halt_silent: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg == MODE_HALT |-> bundle.count == '0)
        else $error("halted scanner produced records");

    a_line_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> line_reg >= $past(line_reg))
        else $error("line counter went backward");

endmodule

/* rtl/core/stok_outbuf.sv */
module stok_outbuf
    import stok_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       load,
    input  bundle_t    bundle,
    output obuf_stat_t stat,
    stok_chan_if.source out_ch
);

    res_t [MAX_RES-1:0] slot_reg;
    logic [1:0]         ptr_reg, ptr_next;
    logic               valid_reg, valid_next;
    logic               take;
    logic               last;

    assign last      = slot_reg[ptr_reg].last_of_run;
    assign take      = valid_reg && out_ch.ready;
    assign stat.free = !valid_reg || (out_ch.ready && last);

    assign out_ch.valid   = valid_reg;
    assign out_ch.payload = slot_reg[ptr_reg];

    always_comb
    begin
        valid_next = valid_reg;
        ptr_next   = ptr_reg;
        if (take)
        begin
            if (last)
                valid_next = 1'b0;
            else
                ptr_next = ptr_reg + 1'b1;
        end
        if (load)
        begin
            valid_next = 1'b1;
            ptr_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            ptr_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            ptr_reg   <= ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            slot_reg <= bundle.slot;
    end

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> stat.free)
        else $error("bundle loaded over undelivered records");

    a_load_starts: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> valid_reg && ptr_reg == '0)
        else $error("new bundle not presented from first slot");

    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        take && !last |=> valid_reg && ptr_reg == $past(ptr_reg) + 2'd1)
        else $error("records of one run dropped");

endmodule

/* rtl/core/source_tokenizer_core.sv */
// Channel | Dir | Payload                                        | Handshake
// in_ch   | in  | in_byte, end_of_input                          | valid/ready
// out_ch  | out | rec_type, token_kind, text_byte, line_number,  | valid/ready
//         |     | token_length, error_code, last_of_run          |
//
// One request per clock is taken while its records have room; each is scanned from its input
// register by combinational logic and yields zero to four records, delivered one per clock
// from the output bundle register while out_ch is ready, so one request per cycle is sustained
// while each makes at most one record; one making more holds the next until its last is taken.
// rst_n (async, active low) returns the scanner to idle on line 1.
// Backpressure on out_ch holds the bundle and then the input register.
module source_tokenizer_core
    import stok_pkg::*;
#(
    parameter int LINE_BITS   = 16,
    parameter int LENGTH_BITS = 12
) (
    input  logic         clk,
    input  logic         rst_n,
    stok_chan_if.sink    in_ch,
    stok_chan_if.source  out_ch
);

    // input register stage
    logic       in_valid_reg;
    in_t        in_data_reg;
    logic       adv;
    bundle_t    bundle;
    obuf_stat_t ob_stat;

    // a request leaves the input register once its records have room
    assign adv         = in_valid_reg && ((bundle.count == '0) || ob_stat.free);
    assign in_ch.ready = !in_valid_reg || adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ch.ready)
        begin
            in_valid_reg <= in_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.ready && in_ch.valid)
            in_data_reg <= in_ch.payload;
    end

    // scanner state and record generation
    stok_scan #(
        .LINE_BITS   (LINE_BITS),
        .LENGTH_BITS (LENGTH_BITS)
    ) u_scan (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (adv),
        .in_data (in_data_reg),
        .bundle  (bundle)
    );

    // record bundle register, drained one record per cycle while out_ch is ready
    stok_outbuf u_outbuf (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (adv && (bundle.count != '0)),
        .bundle (bundle),
        .stat   (ob_stat),
        .out_ch (out_ch)
    );

endmodule

/* dv/source_tokenizer_core_tb.sv */
`timescale 1ns / 100ps

module source_tokenizer_core_tb;
    import stok_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 16;
    localparam int MAX_REPORTS  = 10;

    // Token tracker: mirrors the lexer state per accepted request and keeps
    // the records the block owes us, oldest first.
    class token_checker;
        mode_t               mode;
        logic [KW_NUM-1:0]   kw_alive;
        logic [LINE_FW-1:0]  line_now;
        logic [LINE_FW-1:0]  tok_line;
        logic [LEN_FW-1:0]   tok_len;
        res_t                pending_records[$];
        res_t                step_records[$];
        int                  mismatches;
        string               kw_words[KW_NUM];
        string               op_chars;

        function new();
            mode       = MODE_IDLE;
            kw_alive   = '1;
            line_now   = LINE_FW'(1);
            tok_line   = LINE_FW'(1);
            tok_len    = '0;
            mismatches = 0;
            kw_words   = '{"func", "if", "else", "elseif", "extern", "return"};
            // operator kinds are numbered densely in this order
            op_chars   = "+-/*=(){}[]:,";
        endfunction

        function bit digit(logic [7:0] c);
            return c >= "0" && c <= "9";
        endfunction

        function bit letter(logic [7:0] c);
            return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
        endfunction

        function kind_t op_of(logic [7:0] c);
            for (int i = 0; i < op_chars.len(); i++)
                if (op_chars[i] == c)
                    return kind_t'(K_PLUS + i);
            return K_IDENT;
        endfunction

        function void queue_record(rec_type_t t, kind_t k, logic [7:0] b,
                                   logic [LINE_FW-1:0] ln, logic [LEN_FW-1:0] len, err_t e);
            res_t r;
            if (step_records.size() >= MAX_RES)
                return;
            r.rec_type     = t;
            r.token_kind   = k;
            r.text_byte    = b;
            r.line_number  = ln;
            r.token_length = len;
            r.error_code   = e;
            r.last_of_run  = 1'b0;
            step_records.push_back(r);
        endfunction

        function void text_rec(kind_t k, logic [7:0] c);
            queue_record(REC_TEXT, k, c, tok_line, '0, ERR_NONE);
        endfunction

        function void close_token(kind_t k);
            queue_record(REC_END, k, 8'd0, tok_line, tok_len, ERR_NONE);
        endfunction

        function void grow();
            if (tok_len != '1)
                tok_len++;
        endfunction

        function void halt_with(err_t e, logic [LINE_FW-1:0] ln);
            queue_record(REC_ERROR, K_IDENT, 8'd0, ln, '0, e);
            mode = MODE_HALT;
        endfunction

        function void open_token(mode_t m);
            mode     = m;
            tok_line = line_now;
            tok_len  = '0;
        endfunction

        // drop keywords whose spelling differs at this position
        function void add_letter(logic [7:0] c);
            int pos;
            pos = int'(tok_len);
            for (int k = 0; k < KW_NUM; k++)
                if (pos >= kw_words[k].len() || kw_words[k][pos] != c)
                    kw_alive[k] = 1'b0;
            grow();
            text_rec(K_IDENT, c);
        endfunction

        function void close_word();
            kind_t k;
            k = K_IDENT;
            for (int i = 0; i < KW_NUM; i++)
                if (kw_alive[i] && int'(tok_len) == kw_words[i].len())
                    k = kind_t'(K_KW0 + i);
            close_token(k);
        endfunction

        function void scan_idle(logic [7:0] c);
            kind_t op;
            mode = MODE_IDLE;
            op   = op_of(c);
            if (c == CH_SPACE || c == CH_TAB)
                return;
            if (c == CH_LF) begin
                if (line_now != '1)
                    line_now++;
            end else if (c == CH_SLASH) begin
                open_token(MODE_SLASH);
                grow();
            end else if (c == CH_QUOTE) begin
                open_token(MODE_STRING);
                grow();
            end else if (digit(c)) begin
                open_token(MODE_NUMBER);
                grow();
                text_rec(K_NUMBER, c);
            end else if (letter(c)) begin
                open_token(MODE_IDENT);
                kw_alive = '1;
                add_letter(c);
            end else if (op != K_IDENT) begin
                open_token(MODE_IDLE);
                grow();
                text_rec(op, c);
                close_token(op);
            end else begin
                halt_with(ERR_SYMBOL, line_now);
            end
        endfunction

        function void absorb_request(in_t req);
            logic [7:0] c;
            res_t       r;
            c = req.in_byte;
            step_records.delete();
            if (mode == MODE_HALT)
                return;
            if (req.end_of_input) begin
                case (mode) inside
                    MODE_IDENT:   close_word();
                    MODE_NUMBER:  close_token(K_NUMBER);
                    MODE_SLASH:
                    begin
                        text_rec(K_DIV, CH_SLASH);
                        close_token(K_DIV);
                    end
                    MODE_COMMENT: close_token(K_COMMENT);
                    MODE_STRING, MODE_ESCAPE: halt_with(ERR_UNTERM, tok_line);
                    default: ;
                endcase
                if (mode != MODE_HALT)
                    mode = MODE_IDLE;
            end else begin
                case (mode)
                    MODE_IDENT:
                        if (letter(c) || digit(c))
                            add_letter(c);
                        else begin
                            close_word();
                            scan_idle(c);
                        end
                    MODE_NUMBER:
                        if (digit(c)) begin
                            grow();
                            text_rec(K_NUMBER, c);
                        end else begin
                            close_token(K_NUMBER);
                            scan_idle(c);
                        end
                    MODE_STRING:
                    begin
                        grow();
                        if (c == CH_QUOTE) begin
                            close_token(K_STRING);
                            mode = MODE_IDLE;
                        end else if (c == CH_BSLASH)
                            mode = MODE_ESCAPE;
                        else
                            text_rec(K_STRING, c);
                    end
                    MODE_ESCAPE:
                    begin
                        grow();
                        if (c == CH_N)
                            text_rec(K_STRING, CH_CR);
                        else begin
                            text_rec(K_STRING, CH_BSLASH);
                            text_rec(K_STRING, c);
                        end
                        mode = MODE_STRING;
                    end
                    MODE_SLASH:
                        if (c == CH_SLASH) begin
                            grow();
                            mode = MODE_COMMENT;
                        end else begin
                            text_rec(K_DIV, CH_SLASH);
                            close_token(K_DIV);
                            scan_idle(c);
                        end
                    MODE_COMMENT:
                        if (c == CH_LF) begin
                            close_token(K_COMMENT);
                            scan_idle(c);
                        end else
                            grow();
                    default: scan_idle(c);
                endcase
            end
            if (step_records.size() > 0) begin
                r = step_records.pop_back();
                r.last_of_run = 1'b1;
                step_records.push_back(r);
            end
            foreach (step_records[i])
                pending_records.push_back(step_records[i]);
        endfunction

        function string show(res_t r);
            return $sformatf("type=%0d kind=%0d byte=%02h line=%0d len=%0d err=%0d last=%0b",
                             r.rec_type, r.token_kind, r.text_byte, r.line_number,
                             r.token_length, r.error_code, r.last_of_run);
        endfunction

        function void check_record(res_t got);
            res_t want;
            if (pending_records.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: record with none pending: %s", $realtime, show(got));
                return;
            end
            want = pending_records.pop_front();
            if (got.rec_type !== want.rec_type || got.token_kind !== want.token_kind ||
                got.text_byte !== want.text_byte || got.line_number !== want.line_number ||
                got.token_length !== want.token_length ||
                got.error_code !== want.error_code || got.last_of_run !== want.last_of_run) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: mismatch\n  exp %s\n  got %s", $realtime, show(want), show(got));
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    stok_chan_if #(.payload_t(in_t))  in_ch ();
    stok_chan_if #(.payload_t(res_t)) out_ch ();

    source_tokenizer_core #(
        .LINE_BITS   (16),
        .LENGTH_BITS (12)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    token_checker sb;
    bit           gaps_on;   // random idle bursts on both channels
    int           sent;      // accepted requests

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Watchdog: far above the slowest legal run.
    initial begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("simulation failed");
        $finish;
    end

    // Output side: check every accepted record, stall ready in random bursts.
    initial begin
        int stall;
        stall = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (out_ch.valid && out_ch.ready)
                sb.check_record(out_ch.payload);
            if (stall > 0) begin
                stall--;
                out_ch.ready <= 1'b0;
            end else if (gaps_on && $urandom_range(0, 11) == 0) begin
                stall = $urandom_range(0, 15);
                out_ch.ready <= 1'b0;
            end else
                out_ch.ready <= 1'b1;
        end
    end

    // One request on in_ch; valid stays high into the next call unless a gap
    // is taken, so each step sees a single assignment to valid.
    task automatic push_request(logic [7:0] b, logic eoi);
        in_t r;
        int  gap;
        r.in_byte      = b;
        r.end_of_input = eoi;
        if (gaps_on && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 16);
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.payload <= r;
        do
            @(posedge clk);
        while (!in_ch.ready);
        sb.absorb_request(r);
        sent++;
    endtask

    task automatic send_byte(logic [7:0] b);
        push_request(b, 1'b0);
    endtask

    // byte lane is don't-care with end_of_input, so randomize it
    task automatic send_eoi();
        push_request(8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    function automatic logic [7:0] pick_from(string s);
        return s[$urandom_range(0, s.len() - 1)];
    endfunction

    // Legal outside a string or comment
    function automatic bit plain_ok(logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_QUOTE ||
               sb.digit(c) || sb.letter(c) || sb.op_of(c) != K_IDENT;
    endfunction

    // Close any open string or comment left by noise so the next token
    // starts from a known place.
    task automatic settle();
        if (sb.mode == MODE_COMMENT)
            send_byte(CH_LF);
        else if (sb.mode == MODE_ESCAPE) begin
            send_byte("x");
            send_byte(CH_QUOTE);
        end else if (sb.mode == MODE_STRING)
            send_byte(CH_QUOTE);
    endtask

    // Identifiers: keywords, keyword prefixes and extensions, random words
    task automatic rand_word();
        string w;
        int    n;
        int    r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            w = sb.kw_words[$urandom_range(0, KW_NUM - 1)];
            r = $urandom_range(0, 99);
            if (r < 20)
                w = w.substr(0, w.len() - 2);
            else if (r < 40)
                w = {w, string'(pick_from("abcxyz_019EF"))};
        end else begin
            w = string'(pick_from("abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_"));
            n = $urandom_range(0, 7);
            repeat (n)
                w = {w, string'(pick_from("abcdefilnorstuxyzAZ_0123456789"))};
        end
        send_text(w);
    endtask

    task automatic rand_number();
        int n;
        n = $urandom_range(1, 5);
        repeat (n)
            send_byte(pick_from("0123456789"));
    endtask

    // Quoted string with raw bytes other than quote and backslash, and escape pairs
    task automatic rand_string();
        int         n;
        int         r;
        logic [7:0] b;
        n = $urandom_range(0, 6);
        send_byte(CH_QUOTE);
        repeat (n) begin
            if ($urandom_range(0, 99) < 70) begin
                do
                    b = 8'($urandom_range(0, 255));
                while (b == CH_QUOTE || b == CH_BSLASH);
                send_byte(b);
            end else begin
                send_byte(CH_BSLASH);
                r = $urandom_range(0, 99);
                if (r < 30)
                    send_byte(CH_N);
                else if (r < 45)
                    send_byte(CH_QUOTE);
                else if (r < 55)
                    send_byte(CH_BSLASH);
                else
                    send_byte(8'($urandom_range(0, 255)));
            end
        end
        send_byte(CH_QUOTE);
    endtask

    // Comment body of n bytes, anything but newline; mostly newline-ended
    task automatic rand_comment(int n);
        logic [7:0] b;
        send_text("//");
        repeat (n) begin
            do
                b = 8'($urandom_range(0, 255));
            while (b == CH_LF);
            send_byte(b);
        end
        if ($urandom_range(0, 99) < 85)
            send_byte(CH_LF);
        else
            send_eoi();
    endtask

    // Last act of the run: one error, then four requests the halted block
    // must swallow silently.
    task automatic provoke_halt();
        logic [7:0] b;
        settle();
        if ($urandom_range(0, 1) == 0) begin
            // pending token, if any, ends before the error record
            case ($urandom_range(0, 3))
                0: send_text("ab");
                1: send_text("42");
                2: send_byte(CH_SLASH);
                default: ;
            endcase
            if ($urandom_range(0, 1) == 0)
                b = CH_CR;
            else
                do
                    b = 8'($urandom_range(0, 255));
                while (plain_ok(b));
            send_byte(b);
        end else begin
            // string still open at end of input
            send_byte(CH_QUOTE);
            send_text("q\n");
            if ($urandom_range(0, 1) == 0)
                send_byte(CH_BSLASH);
            send_eoi();
        end
        repeat (4)
            push_request(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    endtask

    initial begin
        int target;
        int pick;
        sb      = new();
        gaps_on = 1'b1;
        sent    = 0;
        rst_n         <= 1'b0;
        in_ch.valid   <= 1'b0;
        in_ch.payload <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: keyword and operators, slash then operator (four records),
        // string with byte extremes and both escape flavors, comment with a
        // high byte, number cut by a slash flushed at end of input, keyword at
        // end of input.
        send_text("if(a_9)");
        send_text("/+");
        send_byte(CH_QUOTE);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_text("\\n\\\"");
        send_byte(CH_QUOTE);
        send_text("//");
        send_byte(8'h80);
        send_byte(CH_LF);
        send_text("\t7/");
        send_eoi();
        send_text("else");
        send_eoi();

        // Random: mostly well-formed tokens with random content, some noise
        // and early ends of input.
        target = sent + 340;
        while (sent < target) begin
            if ($urandom_range(0, 63) == 0)
                gaps_on = !gaps_on;
            settle();
            pick = $urandom_range(0, 99);
            if (pick < 25)
                rand_word();
            else if (pick < 38)
                rand_number();
            else if (pick < 52)
                rand_string();
            else if (pick < 62)
                rand_comment($urandom_range(0, 6));
            else if (pick < 80)
                send_byte(pick_from("+-/*=(){}[]:,"));
            else if (pick < 86)
                send_eoi();
            else
                repeat ($urandom_range(1, 3))
                    send_byte(pick_from(" \t\n/0123456789aefinrxzEIR_+-*=(){}[]:,"));
            if ($urandom_range(0, 99) < 60)
                send_byte(pick_from(" \t\n"));
        end

        // Final stretch, no idling: a comment and a few tokens back to back,
        // then the run ends on an error.
        gaps_on = 1'b0;
        settle();
        rand_comment(8);
        settle();
        send_text("zz 5\n");
        provoke_halt();

        in_ch.valid <= 1'b0;
        while (sb.pending_records.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending_records.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
